>>> hdl/blm_pkg.sv
// blm_pkg: shared constants, register codes and control structs of the battery gauge
// used by every module of battery_level_monitor; depends on nothing

package blm_pkg;

  // averaging window
  localparam int WINDOW_LEN = 16;
  localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);

  // field widths
  localparam int CODE_W = 10;
  localparam int GAIN_W = 16;
  localparam int MV_W   = 14;
  localparam int PCT_W  = 7;
  localparam int DUR_W  = 32;

  // gain is in 1/256 mV per count
  localparam int GAIN_FRAC = 8;
  localparam int SCALE_W   = CODE_W + GAIN_W;

  localparam logic [MV_W-1:0] MV_MAX = {MV_W{1'b1}};

  // running sum of the window
  localparam int SUM_W = MV_W + SLOT_W;

  // capacity scaling
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
  localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
  localparam logic [PCT_W-1:0] PCT_MIN   = 7'd5;
  localparam int PROD_W = MV_W + PCT_W;

  // shared divider
  localparam int DVD_W     = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int DVS_W     = MV_W;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // register port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_VOLT_GAIN   = 2'd0,
    REG_EMPTY_MV    = 2'd1,
    REG_FULL_MV     = 2'd2,
    REG_CRITICAL_MV = 2'd3
  } reg_idx_t;

  localparam logic [GAIN_W-1:0] VOLT_GAIN_RST   = 16'd1189;
  localparam logic [MV_W-1:0]   EMPTY_MV_RST    = 14'd2200;
  localparam logic [MV_W-1:0]   FULL_MV_RST     = 14'd3000;
  localparam logic [MV_W-1:0]   CRITICAL_MV_RST = 14'd2100;

  typedef struct packed {
    logic [GAIN_W-1:0] volt_gain;
    logic [MV_W-1:0]   empty_mv;
    logic [MV_W-1:0]   full_mv;
    logic [MV_W-1:0]   critical_mv;
  } cfg_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic scale;
    logic update;
    logic div_mean_start;
    logic mean_capture;
    logic cap_prep;
    logic div_cap_start;
    logic finish;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

>>> hdl/battery_level_monitor.sv
// battery_level_monitor: top level of the moving-average battery gauge
// depends on blm_pkg, blm_cfg_regs, blm_ctrl, blm_datapath, blm_divider
//
//   channel   direction  handshake                 payload
//   config    in         apb psel/penable/pready   paddr, pwdata, prdata
//   measure   in         in_valid / in_stall       adc_code
//   result    out        out_valid / out_stall     voltage_mv, average_mv, capacity_pct,
//                                                  battery_alarm, alarm_duration
//
// one request at a time: each passes twice through the shared 21-step divider (mean,
// then capacity) between the sequencing states, and the next request is taken in the
// cycle that its result first shows as valid
// a finished result sits in the output registers, so the next request is taken
// while it waits; a stalled result only holds back the end of the next request
// synchronous reset clears the window, alarm and counter; ring contents stay
// unknown until written and are never read before that

module battery_level_monitor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [blm_pkg::ADDR_W-1:0]  paddr,
  input  logic [blm_pkg::DATA_W-1:0]  pwdata,
  output logic [blm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [blm_pkg::CODE_W-1:0]  adc_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [blm_pkg::MV_W-1:0]    voltage_mv,
  output logic [blm_pkg::MV_W-1:0]    average_mv,
  output logic [blm_pkg::PCT_W-1:0]   capacity_pct,
  output logic                        battery_alarm,
  output logic [blm_pkg::DUR_W-1:0]   alarm_duration
);

  blm_pkg::cfg_t       cfg;
  blm_pkg::dp_cmd_t    cmd;
  blm_pkg::dp_status_t status;

  blm_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  blm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  blm_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .adc_code       (adc_code),
    .voltage_mv     (voltage_mv),
    .average_mv     (average_mv),
    .capacity_pct   (capacity_pct),
    .battery_alarm  (battery_alarm),
    .alarm_duration (alarm_duration)
  );

endmodule

>>> hdl/blm_divider.sv
// blm_divider: restoring divider, one quotient bit per cycle
// depends on blm_pkg

module blm_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [blm_pkg::DVD_W-1:0]  dividend,
  input  logic [blm_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [blm_pkg::DVD_W-1:0]  quotient
);

  logic                          busy;
  logic [blm_pkg::DIV_CNT_W-1:0] steps;
  logic [blm_pkg::DVS_W-1:0]     dvs;
  logic [blm_pkg::DVS_W-1:0]     rem;
  logic [blm_pkg::DVD_W-1:0]     shreg;

  logic [blm_pkg::DVS_W:0] rem_shift;
  logic [blm_pkg::DVS_W:0] trial;

  // trial subtraction of the divisor from the shifted remainder
  assign rem_shift = {rem, shreg[blm_pkg::DVD_W-1]};
  assign trial     = rem_shift - {1'b0, dvs};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= blm_pkg::DIV_CNT_W'(blm_pkg::DVD_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == blm_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      dvs   <= divisor;
      rem   <= '0;
      shreg <= dividend;
    end else if (busy) begin
      if (!trial[blm_pkg::DVS_W]) begin
        rem   <= trial[blm_pkg::DVS_W-1:0];
        shreg <= {shreg[blm_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem   <= rem_shift[blm_pkg::DVS_W-1:0];
        shreg <= {shreg[blm_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = shreg;

endmodule

>>> hdl/blm_datapath.sv
// blm_datapath: scaling, reading window, mean and capacity math, alarm and result registers
// depends on blm_pkg and blm_divider

module blm_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  blm_pkg::cfg_t               cfg,
  input  blm_pkg::dp_cmd_t            cmd,
  output blm_pkg::dp_status_t         status,
  input  logic [blm_pkg::CODE_W-1:0]  adc_code,
  output logic [blm_pkg::MV_W-1:0]    voltage_mv,
  output logic [blm_pkg::MV_W-1:0]    average_mv,
  output logic [blm_pkg::PCT_W-1:0]   capacity_pct,
  output logic                        battery_alarm,
  output logic [blm_pkg::DUR_W-1:0]   alarm_duration
);

  // request payload and intermediate values
  logic [blm_pkg::CODE_W-1:0] code_q;
  logic [blm_pkg::MV_W-1:0]   mv_q;
  logic [blm_pkg::MV_W-1:0]   mean_q;
  logic [blm_pkg::PROD_W-1:0] cap_prod;
  logic [blm_pkg::MV_W-1:0]   span;
  logic                       span_degen;
  logic                       mean_below;

  // window state
  logic [blm_pkg::MV_W-1:0]   ring [blm_pkg::WINDOW_LEN];
  logic [blm_pkg::SUM_W-1:0]  reading_sum;
  logic [blm_pkg::CNT_W-1:0]  reading_count;
  logic [blm_pkg::SLOT_W-1:0] write_slot;

  // alarm state
  logic                      alarm_latched;
  logic [blm_pkg::DUR_W-1:0] alarm_counter;

  logic [blm_pkg::SCALE_W-1:0]                    scale_prod;
  logic [blm_pkg::SCALE_W-blm_pkg::GAIN_FRAC-1:0] scale_mv;
  logic                                           window_full;
  logic [blm_pkg::SUM_W-1:0]                      sum_drop;
  logic [blm_pkg::SUM_W-1:0]                      reading_sum_next;
  logic [blm_pkg::SLOT_W-1:0]                     write_slot_next;
  logic [blm_pkg::DVD_W-1:0]                      div_dividend;
  logic [blm_pkg::DVS_W-1:0]                      div_divisor;
  logic                                           div_start;
  logic                                           div_done;
  logic [blm_pkg::DVD_W-1:0]                      div_quotient;
  logic [blm_pkg::PCT_W-1:0]                      pct;
  logic                                           alarm_latched_next;
  logic [blm_pkg::DUR_W-1:0]                      alarm_counter_next;

  // code times gain, fraction dropped
  assign scale_prod = blm_pkg::SCALE_W'(code_q) * blm_pkg::SCALE_W'(cfg.volt_gain);
  assign scale_mv   = scale_prod[blm_pkg::SCALE_W-1:blm_pkg::GAIN_FRAC];

  // window update: a full window drops the reading being overwritten
  assign window_full      = (reading_count >= blm_pkg::CNT_W'(blm_pkg::WINDOW_LEN));
  assign sum_drop         = window_full ? blm_pkg::SUM_W'(ring[write_slot]) : '0;
  assign reading_sum_next = reading_sum - sum_drop + blm_pkg::SUM_W'(mv_q);
  assign write_slot_next  = (write_slot == blm_pkg::SLOT_W'(blm_pkg::WINDOW_LEN - 1))
                            ? '0 : write_slot + 1'b1;

  // shared divider operands
  assign div_start    = cmd.div_mean_start | cmd.div_cap_start;
  assign div_dividend = cmd.div_mean_start ? blm_pkg::DVD_W'(reading_sum)
                                           : blm_pkg::DVD_W'(cap_prod);
  assign div_divisor  = cmd.div_mean_start ? blm_pkg::DVS_W'(reading_count) : span;

  blm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign status.div_done = div_done;

  // capacity from the second quotient, with the span and clamp cases
  always_comb begin
    if (span_degen) begin
      pct = blm_pkg::PCT_MAX;
    end else if (mean_below) begin
      pct = blm_pkg::PCT_MIN;
    end else if (div_quotient > blm_pkg::DVD_W'(blm_pkg::PCT_MAX)) begin
      pct = blm_pkg::PCT_MAX;
    end else if (div_quotient < blm_pkg::DVD_W'(blm_pkg::PCT_MIN)) begin
      pct = blm_pkg::PCT_MIN;
    end else begin
      pct = div_quotient[blm_pkg::PCT_W-1:0];
    end
  end

  // alarm latches on a low mean; the counter runs while latched and saturates
  always_comb begin
    alarm_latched_next = alarm_latched | (mean_q < cfg.critical_mv);
    if (!alarm_latched_next) begin
      alarm_counter_next = '0;
    end else if (&alarm_counter) begin
      alarm_counter_next = alarm_counter;
    end else begin
      alarm_counter_next = alarm_counter + 1'b1;
    end
  end

  // control state: window bookkeeping and alarm
  always_ff @(posedge clk) begin
    if (rst) begin
      reading_sum   <= '0;
      reading_count <= '0;
      write_slot    <= '0;
      alarm_latched <= 1'b0;
      alarm_counter <= '0;
    end else begin
      if (cmd.update) begin
        reading_sum <= reading_sum_next;
        write_slot  <= write_slot_next;
        if (!window_full) begin
          reading_count <= reading_count + 1'b1;
        end
      end
      if (cmd.finish) begin
        alarm_latched <= alarm_latched_next;
        alarm_counter <= alarm_counter_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      code_q <= adc_code;
    end
    if (cmd.scale) begin
      mv_q <= (scale_mv > (blm_pkg::SCALE_W - blm_pkg::GAIN_FRAC)'(blm_pkg::MV_MAX))
              ? blm_pkg::MV_MAX : scale_mv[blm_pkg::MV_W-1:0];
    end
    if (cmd.update) begin
      ring[write_slot] <= mv_q;
    end
    if (cmd.mean_capture) begin
      mean_q <= (div_quotient > blm_pkg::DVD_W'(blm_pkg::MV_MAX))
                ? blm_pkg::MV_MAX : div_quotient[blm_pkg::MV_W-1:0];
    end
    if (cmd.cap_prep) begin
      span_degen <= (cfg.full_mv <= cfg.empty_mv);
      mean_below <= (mean_q <= cfg.empty_mv);
      span       <= cfg.full_mv - cfg.empty_mv;
      cap_prod   <= blm_pkg::PROD_W'(mean_q - cfg.empty_mv) *
                    blm_pkg::PROD_W'(blm_pkg::PCT_SCALE);
    end
    if (cmd.finish) begin
      voltage_mv     <= mv_q;
      average_mv     <= mean_q;
      capacity_pct   <= pct;
      battery_alarm  <= alarm_latched_next;
      alarm_duration <= alarm_counter_next;
    end
  end

endmodule

>>> hdl/blm_ctrl.sv
// blm_ctrl: sequencer for one measurement request and the result handshake
// depends on blm_pkg

module blm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  blm_pkg::dp_status_t status,
  output blm_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_UPDATE,
    ST_MEAN_START,
    ST_MEAN_WAIT,
    ST_CAP_PREP,
    ST_CAP_START,
    ST_CAP_WAIT,
    ST_FINISH
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;
  logic   fire;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign fire     = (state == ST_FINISH) && out_free;

  // datapath commands decoded from the state
  always_comb begin
    cmd                = '0;
    cmd.load_in        = accept;
    cmd.scale          = (state == ST_SCALE);
    cmd.update         = (state == ST_UPDATE);
    cmd.div_mean_start = (state == ST_MEAN_START);
    cmd.mean_capture   = (state == ST_MEAN_WAIT) && status.div_done;
    cmd.cap_prep       = (state == ST_CAP_PREP);
    cmd.div_cap_start  = (state == ST_CAP_START);
    cmd.finish         = fire;
  end

  // state and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE:      state <= ST_UPDATE;
        ST_UPDATE:     state <= ST_MEAN_START;
        ST_MEAN_START: state <= ST_MEAN_WAIT;
        ST_MEAN_WAIT: begin
          if (status.div_done) begin
            state <= ST_CAP_PREP;
          end
        end
        ST_CAP_PREP:   state <= ST_CAP_START;
        ST_CAP_START:  state <= ST_CAP_WAIT;
        ST_CAP_WAIT: begin
          if (status.div_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default:       state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/blm_cfg_regs.sv
// blm_cfg_regs: apb register file for gain and voltage thresholds
// depends on blm_pkg

module blm_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [blm_pkg::ADDR_W-1:0]  paddr,
  input  logic [blm_pkg::DATA_W-1:0]  pwdata,
  output logic [blm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output blm_pkg::cfg_t               cfg
);

  blm_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = blm_pkg::reg_idx_t'(paddr[blm_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes, masked to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volt_gain   <= blm_pkg::VOLT_GAIN_RST;
      cfg.empty_mv    <= blm_pkg::EMPTY_MV_RST;
      cfg.full_mv     <= blm_pkg::FULL_MV_RST;
      cfg.critical_mv <= blm_pkg::CRITICAL_MV_RST;
    end else if (wr_en) begin
      unique case (idx)
        blm_pkg::REG_VOLT_GAIN:   cfg.volt_gain   <= pwdata[blm_pkg::GAIN_W-1:0];
        blm_pkg::REG_EMPTY_MV:    cfg.empty_mv    <= pwdata[blm_pkg::MV_W-1:0];
        blm_pkg::REG_FULL_MV:     cfg.full_mv     <= pwdata[blm_pkg::MV_W-1:0];
        blm_pkg::REG_CRITICAL_MV: cfg.critical_mv <= pwdata[blm_pkg::MV_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      blm_pkg::REG_VOLT_GAIN:   prdata = blm_pkg::DATA_W'(cfg.volt_gain);
      blm_pkg::REG_EMPTY_MV:    prdata = blm_pkg::DATA_W'(cfg.empty_mv);
      blm_pkg::REG_FULL_MV:     prdata = blm_pkg::DATA_W'(cfg.full_mv);
      blm_pkg::REG_CRITICAL_MV: prdata = blm_pkg::DATA_W'(cfg.critical_mv);
      default:                  prdata = '0;
    endcase
  end

endmodule

>>> hdl/blm_checker.sv
// blm_checker: port-level assertions for battery_level_monitor, bound to the top level
// depends on blm_pkg

module blm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [blm_pkg::MV_W-1:0]   voltage_mv,
  input logic [blm_pkg::PCT_W-1:0]  capacity_pct,
  input logic                       battery_alarm,
  input logic [blm_pkg::DUR_W-1:0]  alarm_duration
);

  // an accepted request blocks the input while it is worked on
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted request");

  // capacity inside its clamp range whenever a result is valid
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (capacity_pct >= blm_pkg::PCT_MIN && capacity_pct <= blm_pkg::PCT_MAX))
    else $error("capacity outside 5..100");

  // the alarm counter runs exactly while the alarm is latched
  a_dur_matches_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (battery_alarm == (alarm_duration != '0)))
    else $error("alarm counter disagrees with alarm flag");

  // once shown, the alarm stays until reset
  a_alarm_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && battery_alarm) |=> battery_alarm)
    else $error("alarm released without reset");

  // a stalled result stays valid and its voltage holds
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(voltage_mv)))
    else $error("stalled result changed");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .voltage_mv     (voltage_mv),
  .capacity_pct   (capacity_pct),
  .battery_alarm  (battery_alarm),
  .alarm_duration (alarm_duration)
);

>>> tb/tb.sv
// tb: self-checking testbench for battery_level_monitor, the moving-average battery gauge
// drives measurement requests and register writes, predicts every result and scores it
// depends on blm_pkg and the battery_level_monitor rtl

`timescale 1ns / 1ps

module tb;
  import blm_pkg::*;

  localparam int DRAIN_CYCLES    = 60;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int REPORT_LIMIT    = 10;

  typedef struct {
    logic [MV_W-1:0]  voltage_mv;
    logic [MV_W-1:0]  average_mv;
    logic [PCT_W-1:0] capacity_pct;
    logic             battery_alarm;
    logic [DUR_W-1:0] alarm_duration;
  } reading_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [CODE_W-1:0] adc_code;
  logic              out_valid;
  logic              out_stall;
  logic [MV_W-1:0]   voltage_mv;
  logic [MV_W-1:0]   average_mv;
  logic [PCT_W-1:0]  capacity_pct;
  logic              battery_alarm;
  logic [DUR_W-1:0]  alarm_duration;

  battery_level_monitor dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .adc_code       (adc_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .voltage_mv     (voltage_mv),
    .average_mv     (average_mv),
    .capacity_pct   (capacity_pct),
    .battery_alarm  (battery_alarm),
    .alarm_duration (alarm_duration)
  );

  // register mirror
  logic [GAIN_W-1:0] gain_q;
  logic [MV_W-1:0]   empty_q;
  logic [MV_W-1:0]   full_q;
  logic [MV_W-1:0]   crit_q;

  // window and alarm mirror
  logic [MV_W-1:0]  window [WINDOW_LEN];
  logic [SUM_W-1:0] window_sum;
  int unsigned      window_fill;
  int unsigned      next_slot;
  bit               alarm_on;
  logic [DUR_W-1:0] alarm_count;

  reading_t pending_readings [$];

  int  bad_count;
  int  items_sent;
  int  results_seen;
  int  reg_writes;
  bit  quiet_channels;
  int  hold_request;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 70);
  endfunction

  function automatic logic [ADDR_W-1:0] reg_addr(reg_idx_t idx);
    return ADDR_W'(4 * int'(idx));
  endfunction

  // expected result of one measurement; advances the window and alarm mirror
  function automatic reading_t compute_reading(logic [CODE_W-1:0] code);
    reading_t          r;
    logic [SCALE_W-1:0] prod;
    logic [SCALE_W-1:0] scaled;
    logic [MV_W-1:0]    mv;
    logic [31:0]        mean;
    logic [31:0]        pct;
    prod   = SCALE_W'(code) * SCALE_W'(gain_q);
    scaled = prod >> GAIN_FRAC;
    mv     = (scaled > SCALE_W'(MV_MAX)) ? MV_MAX : scaled[MV_W-1:0];

    // full ring drops its oldest reading from the sum
    if (window_fill >= WINDOW_LEN) window_sum = window_sum - SUM_W'(window[next_slot]);
    else window_fill++;
    window[next_slot] = mv;
    window_sum = window_sum + SUM_W'(mv);
    next_slot = (next_slot + 1) % WINDOW_LEN;

    mean = 32'(window_sum) / window_fill;
    if (mean > 32'(MV_MAX)) mean = 32'(MV_MAX);

    // alarm latches for good, counter saturates
    if (mean < 32'(crit_q)) alarm_on = 1'b1;
    if (alarm_on) begin
      if (alarm_count != '1) alarm_count = alarm_count + 1'b1;
    end else begin
      alarm_count = '0;
    end

    // capacity: degenerate span, below empty, linear with clamp
    if (full_q <= empty_q) begin
      pct = 32'd100;
    end else if (mean <= 32'(empty_q)) begin
      pct = 32'd5;
    end else begin
      pct = ((mean - 32'(empty_q)) * 32'd100) / (32'(full_q) - 32'(empty_q));
      if (pct > 32'd100) pct = 32'd100;
      if (pct < 32'd5) pct = 32'd5;
    end

    r.voltage_mv     = mv;
    r.average_mv     = mean[MV_W-1:0];
    r.capacity_pct   = pct[PCT_W-1:0];
    r.battery_alarm  = alarm_on;
    r.alarm_duration = alarm_count;
    return r;
  endfunction

  task automatic note_bad(string msg);
    bad_count++;
    if (bad_count <= REPORT_LIMIT) $display("[%0t] %s", $time, msg);
  endtask

  // one measurement request, then a random gap
  task automatic send_reading(logic [CODE_W-1:0] code);
    int gap;
    in_valid <= 1'b1;
    adc_code <= code;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(compute_reading(code));
    items_sent++;
    gap = quiet_channels ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every pending result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_VOLT_GAIN:   gain_q  = value[GAIN_W-1:0];
      REG_EMPTY_MV:    empty_q = value[MV_W-1:0];
      REG_FULL_MV:     full_q  = value[MV_W-1:0];
      REG_CRITICAL_MV: crit_q  = value[MV_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic reg_check(reg_idx_t idx);
    logic [DATA_W-1:0] want;
    case (idx)
      REG_VOLT_GAIN:   want = DATA_W'(gain_q);
      REG_EMPTY_MV:    want = DATA_W'(empty_q);
      REG_FULL_MV:     want = DATA_W'(full_q);
      default:         want = DATA_W'(crit_q);
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(idx);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      note_bad($sformatf("register %s read: expected %0d, got %0d", idx.name(), want, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_all_regs();
    reg_check(REG_VOLT_GAIN);
    reg_check(REG_EMPTY_MV);
    reg_check(REG_FULL_MV);
    reg_check(REG_CRITICAL_MV);
  endtask

  // result sink: random stalls, quiet stretches and a long hold-off on request
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (quiet_channels) begin
        out_stall  <= 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // score each accepted result against the oldest prediction
  always @(posedge clk) begin : score_results
    reading_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (pending_readings.size() == 0) begin
        note_bad($sformatf("unexpected result: mv %0d avg %0d pct %0d alarm %0b dur %0d",
                           voltage_mv, average_mv, capacity_pct, battery_alarm,
                           alarm_duration));
      end else begin
        want = pending_readings.pop_front();
        if (voltage_mv !== want.voltage_mv || average_mv !== want.average_mv ||
            capacity_pct !== want.capacity_pct || battery_alarm !== want.battery_alarm ||
            alarm_duration !== want.alarm_duration)
          note_bad($sformatf({"result %0d: expected mv %0d avg %0d pct %0d alarm %0b dur %0d,",
                              " got mv %0d avg %0d pct %0d alarm %0b dur %0d"},
                             results_seen, want.voltage_mv, want.average_mv,
                             want.capacity_pct, want.battery_alarm, want.alarm_duration,
                             voltage_mv, average_mv, capacity_pct, battery_alarm,
                             alarm_duration));
      end
    end
  end

  // reset values read back; alarm threshold parked at zero until the alarm test
  task automatic test_register_defaults();
    check_all_regs();
    reg_write(REG_CRITICAL_MV, 32'd0);
    reg_check(REG_CRITICAL_MV);
  endtask

  // code extremes, gain saturation and zero gain, degenerate spans, ring wrap
  task automatic test_directed();
    send_reading(10'd0);
    send_reading(10'd1023);
    send_reading(10'd1);
    send_reading(10'd512);
    send_reading(10'd341);
    send_reading(10'd682);
    wait_idle();

    // saturated voltage, span of zero width
    reg_write(REG_VOLT_GAIN, 32'd65535);
    reg_write(REG_EMPTY_MV, 32'd5000);
    reg_write(REG_FULL_MV, 32'd5000);
    repeat (4) send_reading(10'd1023);
    wait_idle();

    // zero gain, full below empty
    reg_write(REG_VOLT_GAIN, 32'd0);
    reg_write(REG_EMPTY_MV, 32'd16383);
    reg_write(REG_FULL_MV, 32'd100);
    send_reading(10'd1023);
    send_reading(10'd0);
    send_reading(10'd777);
    send_reading(10'd1023);
    wait_idle();

    // mean above full clamps to 100; ring wraps here
    reg_write(REG_VOLT_GAIN, 32'd1189);
    reg_write(REG_EMPTY_MV, 32'd0);
    reg_write(REG_FULL_MV, 32'd1000);
    send_reading(10'd1023);
    send_reading(10'd1023);
    send_reading(10'd100);
    send_reading(10'd200);
    wait_idle();
    check_all_regs();
  endtask

  // random settings per phase, random codes with random gaps
  task automatic test_random_settings(int phases, int per_phase);
    int gain;
    int typ;
    int empty;
    int full;
    int sel;
    for (int p = 0; p < phases; p++) begin
      sel = $urandom_range(0, 3);
      case (sel)
        0:       gain = $urandom_range(0, 65535);
        1:       gain = $urandom_range(200, 2047);
        2:       gain = 1189;
        default: gain = $urandom_range(0, 1) ? 65535 : 0;
      endcase
      typ = (512 * gain) >> 8;
      if (typ > 16383) typ = 16383;
      empty = $urandom_range(0, typ);
      full  = $urandom_range(0, (2 * typ > 16383) ? 16383 : 2 * typ);
      if ($urandom_range(0, 7) == 0) empty = $urandom_range(0, 1) ? 16383 : 0;
      if ($urandom_range(0, 7) == 0) full = $urandom_range(0, 1) ? 16383 : 0;
      reg_write(REG_VOLT_GAIN, DATA_W'(gain));
      reg_write(REG_EMPTY_MV, DATA_W'(empty));
      reg_write(REG_FULL_MV, DATA_W'(full));
      for (int i = 0; i < per_phase; i++) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) send_reading(10'd0);
        else if (sel == 1) send_reading(10'd1023);
        else send_reading(CODE_W'($urandom_range(0, 1023)));
      end
      wait_idle();
    end
  endtask

  // sink holds off while requests keep coming, then the sender waits for all
  task automatic test_backpressure();
    hold_request   = HOLD_OFF_CYCLES;
    quiet_channels = 1'b1;
    repeat (8) send_reading(CODE_W'($urandom_range(0, 1023)));
    quiet_channels = 1'b0;
    wait_idle();
  endtask

  // back-to-back requests with no stalls
  task automatic test_streaming();
    quiet_channels = 1'b1;
    repeat (60) send_reading(CODE_W'($urandom_range(0, 1023)));
    quiet_channels = 1'b0;
    wait_idle();
  endtask

  // falling battery latches the alarm; later threshold writes never clear it
  task automatic test_alarm();
    reg_write(REG_VOLT_GAIN, 32'd1189);
    reg_write(REG_EMPTY_MV, 32'd2200);
    reg_write(REG_FULL_MV, 32'd3000);
    reg_write(REG_CRITICAL_MV, 32'd3000);
    repeat (40) send_reading(CODE_W'($urandom_range(0, 300)));
    repeat (100) send_reading(CODE_W'($urandom_range(0, 1023)));
    wait_idle();
    reg_write(REG_CRITICAL_MV, 32'd16383);
    repeat (40) send_reading(CODE_W'($urandom_range(0, 1023)));
    wait_idle();
    reg_write(REG_CRITICAL_MV, 32'd0);
    check_all_regs();
    repeat (20) send_reading(CODE_W'($urandom_range(0, 1023)));
    wait_idle();
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    adc_code       = '0;
    quiet_channels = 1'b0;
    hold_request   = 0;
    bad_count      = 0;
    items_sent     = 0;
    results_seen   = 0;
    reg_writes     = 0;
    gain_q         = VOLT_GAIN_RST;
    empty_q        = EMPTY_MV_RST;
    full_q         = FULL_MV_RST;
    crit_q         = CRITICAL_MV_RST;
    window_sum     = '0;
    window_fill    = 0;
    next_slot      = 0;
    alarm_on       = 1'b0;
    alarm_count    = '0;
    foreach (window[i]) window[i] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_defaults();
    test_directed();
    test_random_settings(6, 100);
    test_backpressure();
    test_streaming();
    test_alarm();
    wait_idle();

    $display("run covered %0d measurements and %0d results over %0d register writes",
             items_sent, results_seen, reg_writes);
    $display("incl. saturation, zero gain, degenerate spans, ring wrap, back-pressure, alarm latch");
    if (bad_count == 0 && pending_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", bad_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/blm_pkg.sv
hdl/blm_divider.sv
hdl/blm_datapath.sv
hdl/blm_ctrl.sv
hdl/blm_cfg_regs.sv
hdl/battery_level_monitor.sv
hdl/blm_checker.sv
tb/tb.sv
